/* rtl/jfs_pkg.sv */
// ----------------------------------------------------------------------------
// jfs_pkg
// Types and constants shared by the JPEG frame-size scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jfs_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_START0,
    PH_START1,
    PH_SCAN,
    PH_MARKER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD
  } jfs_phase_t;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } jfs_in_t;

  // Result transaction payload
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } jfs_out_t;

  // Parser state carried from byte to byte
  typedef struct packed {
    jfs_phase_t  phase;
    logic [15:0] seg_rem;
    logic [7:0]  len_hi;
    logic        is_sof;
    logic [2:0]  hdr_idx;
    logic [15:0] held_height;
    logic [15:0] held_width;
    logic        decided;
  } jfs_state_t;

  localparam jfs_state_t STATE_RESET = '{
    phase:       PH_START0,
    seg_rem:     16'd0,
    len_hi:      8'd0,
    is_sof:      1'b0,
    hdr_idx:     3'd0,
    held_height: 16'd0,
    held_width:  16'd0,
    decided:     1'b0
  };

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SOI    = 3'd1;
  localparam logic [2:0] ST_END_SCAN  = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_SHORT_SOF = 3'd4;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd5;
  localparam logic [2:0] ST_TRUNC     = 3'd6;

  // Marker bytes
  localparam logic [7:0] MK_FILL      = 8'hFF;
  localparam logic [7:0] MK_SOI       = 8'hD8;
  localparam logic [7:0] MK_EOI       = 8'hD9;
  localparam logic [7:0] MK_SOS       = 8'hDA;
  localparam logic [7:0] MK_RST_FIRST = 8'hD0;
  localparam logic [7:0] MK_RST_LAST  = 8'hD7;
  localparam logic [7:0] MK_TEM       = 8'h01;
  localparam logic [7:0] MK_SOF_FIRST = 8'hC0;
  localparam logic [7:0] MK_SOF_LAST  = 8'hCF;
  localparam logic [7:0] MK_DHT       = 8'hC4;
  localparam logic [7:0] MK_JPG       = 8'hC8;
  localparam logic [7:0] MK_DAC       = 8'hCC;

  // Segment length limits
  localparam logic [15:0] LEN_MIN         = 16'd2;
  localparam logic [15:0] SOF_PAYLOAD_MIN = 16'd5;

endpackage

`default_nettype wire

/* rtl/jfs_step.sv */
// ----------------------------------------------------------------------------
// jfs_step
// One parser step: next state and optional result for a single file byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jfs_step import jfs_pkg::*; (
  input  var jfs_state_t state_cur,
  input  var jfs_in_t    byte_in,
  output jfs_state_t     state_nxt,
  output logic           res_valid,
  output jfs_out_t       res_data
);

  always_comb begin
    jfs_state_t  s;
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] rem;
    logic        hit;
    logic [2:0]  st;

    s   = state_cur;
    b   = byte_in.data_byte;
    len = {state_cur.len_hi, b};
    rem = 16'd0;
    hit = 1'b0;
    st  = ST_OK;

    // Advance the parser unless this file is already decided
    if (!state_cur.decided) begin
      unique case (state_cur.phase)
        PH_START0: begin
          if (b == MK_FILL) s.phase = PH_START1;
          else begin
            hit = 1'b1;
            st  = ST_NO_SOI;
          end
        end
        PH_START1: begin
          if (b == MK_SOI) s.phase = PH_SCAN;
          else begin
            hit = 1'b1;
            st  = ST_NO_SOI;
          end
        end
        PH_SCAN: begin
          if (b == MK_FILL) s.phase = PH_MARKER;
        end
        PH_MARKER: begin
          if (b == MK_FILL) begin
            s.phase = PH_MARKER;
          end else if (b == MK_EOI || b == MK_SOS) begin
            hit = 1'b1;
            st  = ST_END_SCAN;
          end else if ((b >= MK_RST_FIRST && b <= MK_RST_LAST) || b == MK_TEM) begin
            s.phase = PH_SCAN;
          end else begin
            s.is_sof = (b >= MK_SOF_FIRST) && (b <= MK_SOF_LAST) &&
                       (b != MK_DHT) && (b != MK_JPG) && (b != MK_DAC);
            s.phase  = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          s.len_hi = b;
          s.phase  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len < LEN_MIN) begin
            hit = 1'b1;
            st  = ST_BAD_LEN;
          end else begin
            rem       = len - LEN_MIN;
            s.seg_rem = rem;
            s.hdr_idx = 3'd0;
            if (state_cur.is_sof) begin
              if (rem < SOF_PAYLOAD_MIN) begin
                hit = 1'b1;
                st  = ST_SHORT_SOF;
              end else begin
                s.phase = PH_PAYLOAD;
              end
            end else begin
              s.phase = (rem == 16'd0) ? PH_SCAN : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          // Capture height and width from frame header bytes 1 to 4
          if (state_cur.is_sof && state_cur.hdr_idx < 3'd5) begin
            case (state_cur.hdr_idx)
              3'd1:    s.held_height[15:8] = b;
              3'd2:    s.held_height[7:0]  = b;
              3'd3:    s.held_width[15:8]  = b;
              3'd4:    s.held_width[7:0]   = b;
              default: s.held_height       = state_cur.held_height;
            endcase
            s.hdr_idx = state_cur.hdr_idx + 3'd1;
          end
          if (state_cur.seg_rem != 16'd0) s.seg_rem = state_cur.seg_rem - 16'd1;
          if (s.seg_rem == 16'd0) begin
            if (state_cur.is_sof) begin
              hit = 1'b1;
              st  = (s.held_width != 16'd0 && s.held_height != 16'd0) ? ST_OK
                                                                     : ST_ZERO_SIZE;
            end else begin
              s.phase = PH_SCAN;
            end
          end
        end
        default: s.phase = PH_SCAN;
      endcase
      if (hit) s.decided = 1'b1;
    end

    // Close the file on its last byte
    if (byte_in.last_byte && !s.decided) begin
      hit = 1'b1;
      st  = (s.phase == PH_START0 || s.phase == PH_START1) ? ST_NO_SOI : ST_TRUNC;
    end

    res_valid = hit;
    res_data.status = st;
    if (st == ST_OK || st == ST_ZERO_SIZE) begin
      res_data.image_width  = s.held_width;
      res_data.image_height = s.held_height;
    end else begin
      res_data.image_width  = 16'd0;
      res_data.image_height = 16'd0;
    end

    state_nxt = byte_in.last_byte ? STATE_RESET : s;
  end

endmodule

`default_nettype wire

/* rtl/jpeg_frame_size_scanner_unit.sv */
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner_unit
// Scans a JPEG byte stream for the first frame header and reports its size.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one file byte per transaction, with last_byte set
//   on the final byte of each file. out_valid/out_ready carry one result per
//   file: a status code plus the width and height from the frame header.
//   The result leaves on the byte that decides it, or on the last byte;
//   bytes after a decision, up to the end of the file, give no result.
// Path: a deciding byte is held in the input register, parsed by the single
//   parser step and loaded into the result register, which drives out_valid.
// Throughput: one byte per cycle while no result waits for out_ready; the
//   parser advances one byte a cycle, limited by the single parser step
//   between the two registers.
// Stall: while a result waits for out_ready, the parser holds one buffered
//   byte and in_ready falls only when both registers are full; nothing is
//   lost or repeated.
// Reset: synchronous, active low rst_n; clears both valid flags and returns
//   the parser to expect the start marker of a new file.
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_frame_size_scanner_unit import jfs_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_ready,
  input  var jfs_in_t  in_data,
  output logic         out_valid,
  input  wire          out_ready,
  output jfs_out_t     out_data
);

  logic       s1_valid_r;
  jfs_in_t    s1_data_r;
  jfs_state_t state_r;
  jfs_state_t state_nxt;
  logic       out_valid_r;
  jfs_out_t   out_data_r;
  logic       res_valid;
  jfs_out_t   res_data;
  logic       out_free;
  logic       s1_fire;
  logic       in_fire;

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  jfs_step u_step (
    .state_cur (state_r),
    .byte_in   (s1_data_r),
    .state_nxt (state_nxt),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // Input register: hold the accepted byte until the parser takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
    if (in_fire) s1_data_r <= in_data;
  end

  // Parser state: advance once per byte taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register: load on a decision, drop once delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_fire && res_valid) out_data_r <= res_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/jfs_checker.sv */
// ----------------------------------------------------------------------------
// jfs_checker
// Port-level checks for the JPEG frame-size scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jfs_checker import jfs_pkg::*; (
  input wire          clk,
  input wire          rst_n,
  input wire          in_ready,
  input wire          out_valid,
  input wire          out_ready,
  input var jfs_out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_TRUNC)
    else $error("undefined status code");

  // Size is reported only with ok or zero-size status
  a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK && out_data.status != ST_ZERO_SIZE
    |-> out_data.image_width == 16'd0 && out_data.image_height == 16'd0)
    else $error("size reported with failure status");

  // Reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input is never refused while the result side is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind jpeg_frame_size_scanner_unit jfs_checker u_jfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* tb/sv/jfs_size_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jfs_size_checker
// Watches both channels of the JPEG frame-size scanner, predicts the result
// of every file from the accepted bytes and compares each result transaction
// field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module jfs_size_checker import jfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  jfs_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  jfs_out_t out_data,
  output int       fail_count,
  output int       pending,
  output int       checked
);

  // Parser state of the predictor
  jfs_phase_t  scan_phase;
  logic [15:0] seg_left;
  logic [7:0]  len_msb;
  logic        in_sof;
  logic [2:0]  hdr_pos;
  logic [15:0] frame_h;
  logic [15:0] frame_w;
  logic        settled;

  // Predicted results, oldest first
  jfs_out_t expected_sizes[$];

  int error_total = 0;
  int queued      = 0;
  int compared    = 0;

  assign fail_count = error_total;
  assign pending    = queued;
  assign checked    = compared;

  function automatic logic is_sof_marker(input logic [7:0] m);
    return (m >= MK_SOF_FIRST) && (m <= MK_SOF_LAST) &&
           (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
  endfunction

  // Return the parser to the start of a new file
  function automatic void clear_parser();
    scan_phase = PH_START0;
    seg_left   = 16'd0;
    len_msb    = 8'd0;
    in_sof     = 1'b0;
    hdr_pos    = 3'd0;
    frame_h    = 16'd0;
    frame_w    = 16'd0;
    settled    = 1'b0;
  endfunction

  // Size fields are only carried for a good or a zero-size frame
  function automatic jfs_out_t size_report(input logic [2:0] st);
    jfs_out_t r;
    r.status = st;
    if (st == ST_OK || st == ST_ZERO_SIZE) begin
      r.image_width  = frame_w;
      r.image_height = frame_h;
    end else begin
      r.image_width  = 16'd0;
      r.image_height = 16'd0;
    end
    return r;
  endfunction

  // Advance the predictor by one accepted byte
  function automatic void parse_byte(input jfs_in_t item);
    logic [7:0]  b;
    logic [15:0] seg_len;
    logic        hit;
    logic [2:0]  st;
    b   = item.data_byte;
    hit = 1'b0;
    st  = ST_OK;
    if (!settled) begin
      case (scan_phase)
        PH_START0: begin
          if (b == MK_FILL) scan_phase = PH_START1;
          else begin
            hit = 1'b1;
            st  = ST_NO_SOI;
          end
        end
        PH_START1: begin
          if (b == MK_SOI) scan_phase = PH_SCAN;
          else begin
            hit = 1'b1;
            st  = ST_NO_SOI;
          end
        end
        PH_SCAN: begin
          if (b == MK_FILL) scan_phase = PH_MARKER;
        end
        PH_MARKER: begin
          // a fill byte holds the phase
          if (b != MK_FILL) begin
            if (b == MK_EOI || b == MK_SOS) begin
              hit = 1'b1;
              st  = ST_END_SCAN;
            end else if ((b >= MK_RST_FIRST && b <= MK_RST_LAST) || b == MK_TEM) begin
              scan_phase = PH_SCAN;
            end else begin
              in_sof     = is_sof_marker(b);
              scan_phase = PH_LEN_HI;
            end
          end
        end
        PH_LEN_HI: begin
          len_msb    = b;
          scan_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          seg_len = {len_msb, b};
          if (seg_len < LEN_MIN) begin
            hit = 1'b1;
            st  = ST_BAD_LEN;
          end else begin
            seg_left = seg_len - LEN_MIN;
            hdr_pos  = 3'd0;
            if (in_sof) begin
              if (seg_left < SOF_PAYLOAD_MIN) begin
                hit = 1'b1;
                st  = ST_SHORT_SOF;
              end else begin
                scan_phase = PH_PAYLOAD;
              end
            end else begin
              scan_phase = (seg_left == 16'd0) ? PH_SCAN : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          // capture height and width from the frame header bytes
          if (in_sof && hdr_pos < SOF_PAYLOAD_MIN) begin
            case (hdr_pos)
              3'd1: frame_h[15:8] = b;
              3'd2: frame_h[7:0]  = b;
              3'd3: frame_w[15:8] = b;
              3'd4: frame_w[7:0]  = b;
              default: ;
            endcase
            hdr_pos = hdr_pos + 3'd1;
          end
          if (seg_left > 16'd0) seg_left = seg_left - 16'd1;
          if (seg_left == 16'd0) begin
            if (in_sof) begin
              hit = 1'b1;
              st  = (frame_w != 16'd0 && frame_h != 16'd0) ? ST_OK : ST_ZERO_SIZE;
            end else begin
              scan_phase = PH_SCAN;
            end
          end
        end
        default: scan_phase = PH_SCAN;
      endcase
      if (hit) begin
        expected_sizes.push_back(size_report(st));
        settled = 1'b1;
      end
    end
    // end of file: report if still undecided, then start over
    if (item.last_byte) begin
      if (!settled)
        expected_sizes.push_back(size_report((scan_phase <= PH_START1) ? ST_NO_SOI : ST_TRUNC));
      clear_parser();
    end
  endfunction

  // Compare one result transaction with the oldest prediction
  function automatic void check_result(input jfs_out_t got);
    jfs_out_t want;
    compared++;
    if (expected_sizes.size() == 0) begin
      if (error_total < 10)
        $display("%0t: result with nothing predicted: status %0d width %0d height %0d",
                 $time, got.status, got.image_width, got.image_height);
      error_total++;
    end else begin
      want = expected_sizes.pop_front();
      if (got.status !== want.status || got.image_width !== want.image_width ||
          got.image_height !== want.image_height) begin
        if (error_total < 10)
          $display("%0t: result %0d wrong: status %0d/%0d width %0d/%0d height %0d/%0d (exp/got)",
                   $time, compared, want.status, got.status, want.image_width,
                   got.image_width, want.image_height, got.image_height);
        error_total++;
      end
    end
  endfunction

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_sizes.delete();
    end else begin
      if (in_valid && in_ready) parse_byte(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    queued = expected_sizes.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the JPEG frame-size scanner with directed and random byte files,
// throttles both channels in random bursts, and gives the final verdict from
// the failure and pending counts of the checker running beside the block.
// ----------------------------------------------------------------------------

module testbench;
  import jfs_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  jfs_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  jfs_out_t out_data;

  int fail_count;
  int pending;
  int checked;

  logic       calm = 1'b0;
  int         in_gap_pct = 20;
  int         bytes_sent = 0;
  int         files_sent = 0;
  logic [7:0] file_bytes[$];

  jpeg_frame_size_scanner_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  jfs_size_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Send the file held in file_bytes, one transaction per byte
  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      if (!calm && in_gap_pct > 0 && $urandom_range(1, 100) <= in_gap_pct) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      in_data  = {file_bytes[i], (i == file_bytes.size() - 1)};
      in_valid = 1'b1;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
      bytes_sent++;
    end
    files_sent++;
  endtask

  // Append a plain segment with a random body
  function automatic void add_segment(input logic [7:0] marker, input int body);
    logic [15:0] seg_len;
    seg_len = 16'(body + 2);
    file_bytes.push_back(MK_FILL);
    file_bytes.push_back(marker);
    file_bytes.push_back(seg_len[15:8]);
    file_bytes.push_back(seg_len[7:0]);
    repeat (body) file_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Append a frame header carrying the given size, plus extra component bytes
  function automatic void add_frame(input logic [7:0] marker, input logic [15:0] h,
                                    input logic [15:0] w, input int extra);
    logic [15:0] seg_len;
    seg_len = 16'(7 + extra);
    file_bytes.push_back(MK_FILL);
    file_bytes.push_back(marker);
    file_bytes.push_back(seg_len[15:8]);
    file_bytes.push_back(seg_len[7:0]);
    file_bytes.push_back(8'h08);
    file_bytes.push_back(h[15:8]);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[7:0]);
    repeat (extra) file_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] pick_sof_marker();
    logic [7:0] m;
    do m = MK_SOF_FIRST + 8'($urandom_range(0, 15));
    while (m == MK_DHT || m == MK_JPG || m == MK_DAC);
    return m;
  endfunction

  // Markers that open a segment to be skipped
  function automatic logic [7:0] pick_table_marker();
    logic [7:0] m;
    case ($urandom_range(0, 7))
      0: m = 8'hE0 + 8'($urandom_range(0, 15));
      1: m = MK_DHT;
      2: m = MK_JPG;
      3: m = MK_DAC;
      4: m = 8'hFE;
      5: m = 8'hDB;
      default: m = 8'($urandom_range(2, 8'hBF));
    endcase
    return m;
  endfunction

  function automatic logic [15:0] pick_dim();
    logic [15:0] d;
    case ($urandom_range(0, 7))
      0: d = 16'h0000;
      1: d = 16'hFFFF;
      default: d = 16'($urandom_range(1, 16'hFFFF));
    endcase
    return d;
  endfunction

  // Mostly well-formed files with random content, the rest broken or noise
  function automatic void build_random_file();
    int kind;
    int keep;
    file_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      file_bytes.push_back(MK_FILL);
      file_bytes.push_back(MK_SOI);
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 4))
          0: repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom_range(0, 8'hFE)));
          1: begin
            file_bytes.push_back(MK_FILL);
            file_bytes.push_back(($urandom_range(0, 8) == 8) ? MK_TEM
                                 : MK_RST_FIRST + 8'($urandom_range(0, 7)));
          end
          2: repeat ($urandom_range(1, 3)) file_bytes.push_back(MK_FILL);
          default: add_segment(pick_table_marker(), $urandom_range(0, 6));
        endcase
      end
      add_frame(pick_sof_marker(), pick_dim(), pick_dim(), $urandom_range(0, 3));
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 7) begin
      // length too small, frame header too short, or a short segment to skip
      file_bytes.push_back(MK_FILL);
      file_bytes.push_back(MK_SOI);
      file_bytes.push_back(MK_FILL);
      file_bytes.push_back($urandom_range(0, 1) ? pick_sof_marker() : pick_table_marker());
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'($urandom_range(0, 6)));
      repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      // noise, biased towards marker bytes
      if ($urandom_range(0, 1)) begin
        file_bytes.push_back(MK_FILL);
        file_bytes.push_back(MK_SOI);
      end
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 5))
          0: file_bytes.push_back(MK_FILL);
          1: file_bytes.push_back(MK_EOI);
          2: file_bytes.push_back(MK_SOS);
          3: file_bytes.push_back(MK_TEM);
          default: file_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    // cut some files short
    if ($urandom_range(0, 7) == 0 && file_bytes.size() > 1) begin
      keep = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
  endfunction

  // Result side back-pressure in random bursts
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no start marker, decided on the only byte
    file_bytes = '{8'h00};
    send_file();
    // start marker incomplete at the last byte
    file_bytes = '{MK_FILL};
    send_file();
    // start marker complete, then truncated
    file_bytes = '{MK_FILL, MK_SOI};
    send_file();
    // scan marker, trailing bytes ignored
    file_bytes = '{MK_FILL, MK_SOI, MK_FILL, MK_SOS, 8'h55, MK_FILL};
    send_file();
    // junk byte, then end of image
    file_bytes = '{MK_FILL, MK_SOI, 8'h00, MK_FILL, MK_EOI};
    send_file();
    // segment length below two
    file_bytes = '{MK_FILL, MK_SOI, MK_FILL, 8'hC1, 8'h00, 8'h01};
    send_file();
    // frame header payload too short
    file_bytes = '{MK_FILL, MK_SOI, MK_FILL, MK_SOF_LAST, 8'h00, 8'h06};
    send_file();
    // zero height, decided on the last byte
    file_bytes = '{MK_FILL, MK_SOI};
    add_frame(MK_SOF_FIRST, 16'h0000, 16'h0001, 0);
    send_file();
    // standalone markers, empty segment, fill byte, largest size
    file_bytes = '{MK_FILL, MK_SOI, 8'h00, MK_FILL, MK_TEM, MK_FILL, MK_RST_LAST};
    add_segment(8'hFE, 0);
    file_bytes.push_back(MK_FILL);
    add_frame(8'hC2, 16'hFFFF, 16'hFFFF, 2);
    file_bytes.push_back(8'hAA);
    send_file();

    // random files with varying input pressure
    while (bytes_sent < 600 || files_sent < 45) begin
      case ($urandom_range(0, 2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 10;
        default: in_gap_pct = 35;
      endcase
      build_random_file();
      send_file();
    end

    // final stretch with no idling on either side
    calm = 1'b1;
    repeat (6) begin
      build_random_file();
      send_file();
    end
    in_valid = 1'b0;

    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (pending != 0) $display("%0d predicted results never arrived", pending);
    $display("Sent %0d bytes in %0d files; %0d results compared, %0d failures.",
             bytes_sent, files_sent, checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("jpeg_frame_size_scanner_unit: match");
    end else begin
      $display("jpeg_frame_size_scanner_unit: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Run timed out after %0d bytes", bytes_sent);
    $display("jpeg_frame_size_scanner_unit: mismatch");
    $finish;
  end

endmodule

/* files.f */
rtl/jfs_pkg.sv
rtl/jfs_step.sv
rtl/jpeg_frame_size_scanner_unit.sv
rtl/jfs_checker.sv
tb/sv/jfs_size_checker.sv
tb/sv/testbench.sv
